FILE: rtl/accpu_pkg.sv
// Shared constants, codes and types for the 8-bit accumulator machine.
// No dependencies; used by every module of the block.
package accpu_pkg;

   localparam int MEM_WORDS = 32;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 8;
   localparam int OPC_W     = 3;
   localparam int ITEM_OP_W = 2;

   // item kinds carried on req_tuser
   localparam logic [ITEM_OP_W-1:0] ITEM_LOAD    = 2'd0;
   localparam logic [ITEM_OP_W-1:0] ITEM_STEP    = 2'd1;
   localparam logic [ITEM_OP_W-1:0] ITEM_RESTART = 2'd2;

   // instruction opcodes, top three bits of a memory word
   localparam logic [OPC_W-1:0] OPC_STA = 3'd0;
   localparam logic [OPC_W-1:0] OPC_LDA = 3'd1;
   localparam logic [OPC_W-1:0] OPC_BEQ = 3'd2;
   localparam logic [OPC_W-1:0] OPC_NOP = 3'd3;
   localparam logic [OPC_W-1:0] OPC_DEC = 3'd4;
   localparam logic [OPC_W-1:0] OPC_INC = 3'd5;
   localparam logic [OPC_W-1:0] OPC_JMP = 3'd6;
   localparam logic [OPC_W-1:0] OPC_HLT = 3'd7;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] word_type;
   typedef logic [OPC_W-1:0]  opc_type;

   // machine state after one item, plus the memory write it causes
   typedef struct packed {
      word_type acc;
      addr_type pc;
      logic     halt;
      logic     mem_we;
      addr_type mem_addr;
      word_type mem_data;
      opc_type  executed;
   } exec_type;

endpackage

FILE: rtl/accpu_regfile.sv
// 32 x 8 flop memory: one write port, instruction fetch and operand read ports.
// Depends on accpu_pkg.
module accpu_regfile (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  accpu_pkg::addr_type wr_addr,
   input  accpu_pkg::word_type wr_data,
   input  accpu_pkg::addr_type fetch_addr,
   output accpu_pkg::word_type fetch_data,
   input  accpu_pkg::addr_type oper_addr,
   output accpu_pkg::word_type oper_data
);
   import accpu_pkg::*;

   word_type mem_ff [MEM_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign fetch_data = mem_ff[fetch_addr];
   assign oper_data  = mem_ff[oper_addr];

endmodule

FILE: rtl/accpu_exec.sv
// Decode and execute of one item against the current machine state.
// Depends on accpu_pkg.
module accpu_exec (
   input  logic [accpu_pkg::ITEM_OP_W-1:0] item_op,
   input  accpu_pkg::addr_type load_address,
   input  accpu_pkg::word_type load_data,
   input  accpu_pkg::word_type acc,
   input  accpu_pkg::addr_type pc,
   input  logic                halt,
   input  accpu_pkg::word_type fetch_word,
   output accpu_pkg::addr_type oper_addr,
   input  accpu_pkg::word_type oper_word,
   output accpu_pkg::exec_type nxt
);
   import accpu_pkg::*;

   opc_type  opcode;
   addr_type x;
   addr_type pc_inc;

   assign opcode    = fetch_word[DATA_W-1 -: OPC_W];
   assign x         = fetch_word[ADDR_W-1:0];
   assign pc_inc    = pc + addr_type'(1);
   assign oper_addr = x;

   always_comb begin
      nxt          = '0;
      nxt.acc      = acc;
      nxt.pc       = pc;
      nxt.halt     = halt;
      nxt.mem_addr = x;
      nxt.mem_data = acc;
      case (item_op)
         ITEM_LOAD: begin
            nxt.mem_we   = 1'b1;
            nxt.mem_addr = load_address;
            nxt.mem_data = load_data;
         end
         ITEM_STEP: begin
            if (!halt) begin
               nxt.executed = opcode;
               case (opcode)
                  OPC_STA: begin
                     nxt.mem_we = 1'b1;
                     nxt.pc     = pc_inc;
                  end
                  OPC_LDA: begin
                     nxt.acc = oper_word;
                     nxt.pc  = pc_inc;
                  end
                  OPC_BEQ: nxt.pc = (acc == '0) ? x : pc_inc;
                  OPC_NOP: nxt.pc = pc_inc;
                  OPC_DEC: begin
                     nxt.acc = acc - word_type'(1);
                     nxt.pc  = pc_inc;
                  end
                  OPC_INC: begin
                     nxt.acc = acc + word_type'(1);
                     nxt.pc  = pc_inc;
                  end
                  OPC_JMP: nxt.pc = x;
                  default: nxt.halt = 1'b1;   // halt: pc holds
               endcase
            end
         end
         ITEM_RESTART: begin
            nxt.acc  = '0;
            nxt.pc   = '0;
            nxt.halt = 1'b0;
         end
         default: ;   // unused item kind: state unchanged
      endcase
   end

endmodule

FILE: rtl/accumulator_cpu_8bit_step_core.sv
// Top level of the 8-bit accumulator machine: input register, execute, result register.
// Depends on accpu_pkg, accpu_regfile and accpu_exec.
//
// Usage
//   req channel: one item per handshake. req_tuser gives the item kind (load a
//   memory byte, execute one instruction, restart); req_tdata carries the load
//   address and data, ignored by other kinds.
//   rsp channel: exactly one item per request item, in order, showing the
//   accumulator, program counter, halt flag and executed opcode after it.
//   Timing: the input register takes the item at the accepting edge; machine
//   state and the result register, and so rsp_tvalid, are written when the item
//   fires, which a pending result with rsp_tready low holds back.
//   Throughput: one item per cycle while results are taken. The whole instruction
//   (fetch from the flop memory, decode, operand read, write back) sits between the
//   input register and the result register, so consecutive steps chain directly.
//   Reset: accumulator, program counter and halt flag cleared, all 32 memory
//   bytes zeroed, both stages emptied. req_tready stays low while reset is
//   high and is ready again the cycle after reset.
//   Stall: when rsp_tready is low with a result pending, the input register
//   holds its item and req_tready drops once that register is full too.
module accumulator_cpu_8bit_step_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] load_address, [12:5] load_data, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] accumulator, [12:8] program_counter,
                                    // [13] halted, [16:14] executed_opcode, rest zero
);
   import accpu_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ITEM_OP_W-1:0] in_op_ff,    in_op_in;
   addr_type             in_addr_ff,  in_addr_in;
   word_type             in_data_ff,  in_data_in;

   // machine state
   word_type acc_ff,  acc_in;
   addr_type pc_ff,   pc_in;
   logic     halt_ff, halt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff,  rsp_data_in;

   logic     advance;
   logic     fire;
   word_type fetch_word;
   word_type oper_word;
   addr_type oper_addr;
   exec_type nxt;

   // result register free or being emptied this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !reset && (!in_valid_ff || advance);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   accpu_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (fire && nxt.mem_we),
      .wr_addr    (nxt.mem_addr),
      .wr_data    (nxt.mem_data),
      .fetch_addr (pc_ff),
      .fetch_data (fetch_word),
      .oper_addr  (oper_addr),
      .oper_data  (oper_word)
   );

   accpu_exec u_exec (
      .item_op      (in_op_ff),
      .load_address (in_addr_ff),
      .load_data    (in_data_ff),
      .acc          (acc_ff),
      .pc           (pc_ff),
      .halt         (halt_ff),
      .fetch_word   (fetch_word),
      .oper_addr    (oper_addr),
      .oper_word    (oper_word),
      .nxt          (nxt)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_addr_in   = in_addr_ff;
      in_data_in   = in_data_ff;
      acc_in       = acc_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_op_in    = req_tuser;
         in_addr_in  = req_tdata[ADDR_W-1:0];
         in_data_in  = req_tdata[ADDR_W +: DATA_W];
      end

      if (fire) begin
         acc_in       = nxt.acc;
         pc_in        = nxt.pc;
         halt_in      = nxt.halt;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, nxt.executed, nxt.halt, nxt.pc, nxt.acc};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_addr_ff  <= in_addr_in;
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
